// File: rtl/stack_machine_execute_unit_macros.svh
// Assertion macros used by the execute unit checker
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMEU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smeu assertion failed");

// next-cycle implication, disabled in reset
`define SMEU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smeu assertion failed");

`endif

// File: rtl/smeu_pkg.sv
// Constants, opcodes, state type and decode tables of the stack machine execute unit
package smeu_pkg;

   localparam int WORD_W      = 64;
   localparam int IP_W        = 16;
   localparam int STACK_DEPTH = 256;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SIDX_W      = $clog2(STACK_DEPTH);
   localparam int HEAP_BYTES  = 4096;
   localparam int HIDX_W      = $clog2(HEAP_BYTES);
   localparam int HCNT_W      = $clog2(HEAP_BYTES + 1);

   localparam logic [5:0] OP_PUSH8  = 6'd0;
   localparam logic [5:0] OP_PUSH16 = 6'd1;
   localparam logic [5:0] OP_PUSH32 = 6'd2;
   localparam logic [5:0] OP_PUSH64 = 6'd3;
   localparam logic [5:0] OP_POP    = 6'd4;
   localparam logic [5:0] OP_DUP    = 6'd5;
   localparam logic [5:0] OP_SWAP   = 6'd6;
   localparam logic [5:0] OP_ADD    = 6'd7;
   localparam logic [5:0] OP_SUB    = 6'd8;
   localparam logic [5:0] OP_MUL    = 6'd9;
   localparam logic [5:0] OP_DIVU   = 6'd10;
   localparam logic [5:0] OP_MODU   = 6'd11;
   localparam logic [5:0] OP_AND    = 6'd12;
   localparam logic [5:0] OP_OR     = 6'd13;
   localparam logic [5:0] OP_XOR    = 6'd14;
   localparam logic [5:0] OP_NOT    = 6'd15;
   localparam logic [5:0] OP_SHL    = 6'd16;
   localparam logic [5:0] OP_SHR    = 6'd17;
   localparam logic [5:0] OP_LOAD8  = 6'd18;
   localparam logic [5:0] OP_LOAD64 = 6'd21;
   localparam logic [5:0] OP_STORE8 = 6'd22;
   localparam logic [5:0] OP_STORE64 = 6'd25;
   localparam logic [5:0] OP_JMP    = 6'd26;
   localparam logic [5:0] OP_JZ     = 6'd27;
   localparam logic [5:0] OP_JNZ    = 6'd28;
   localparam logic [5:0] OP_JG     = 6'd29;
   localparam logic [5:0] OP_JL     = 6'd30;
   localparam logic [5:0] OP_JGE    = 6'd31;
   localparam logic [5:0] OP_JLE    = 6'd32;
   localparam logic [5:0] OP_CALL   = 6'd33;
   localparam logic [5:0] OP_RET    = 6'd34;
   localparam logic [5:0] OP_HOST   = 6'd35;
   localparam logic [5:0] OP_THREAD = 6'd36;
   localparam logic [5:0] OP_HALT   = 6'd37;
   localparam logic [5:0] OP_START  = 6'd38;
   localparam logic [5:0] OP_PUSHP  = 6'd39;

   localparam logic [3:0] ST_OK     = 4'd0;
   localparam logic [3:0] ST_HALT   = 4'd1;
   localparam logic [3:0] ST_UNDER  = 4'd2;
   localparam logic [3:0] ST_OVER   = 4'd3;
   localparam logic [3:0] ST_DIVZ   = 4'd4;
   localparam logic [3:0] ST_HEAP   = 4'd5;
   localparam logic [3:0] ST_HOST   = 4'd6;
   localparam logic [3:0] ST_IDLE   = 4'd7;
   localparam logic [3:0] ST_BADCMD = 4'd8;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RDB, S_RDA, S_EXEC, S_MULDIV,
      S_HRD, S_HDAT, S_WR0, S_WR1, S_TOP, S_TOPC
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic is_div;
      logic is_mod;
   } md_ctl_type;

   // immediate bytes that follow the opcode
   function automatic logic [3:0] imm_len(input logic [5:0] cmd);
      logic [3:0] n;
      case (cmd) inside
         OP_PUSH8:           n = 4'd1;
         OP_PUSH16:          n = 4'd2;
         OP_PUSH32:          n = 4'd4;
         OP_PUSH64:          n = 4'd8;
         [OP_JMP:OP_JLE]:    n = 4'd2;
         OP_HOST:            n = 4'd1;
         default:            n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] need_cnt(input logic [5:0] cmd);
      logic [1:0] n;
      case (cmd) inside
         OP_POP, OP_DUP, OP_NOT, [OP_LOAD8:OP_LOAD64],
         OP_JZ, OP_JNZ, OP_CALL, OP_RET, OP_HOST:      n = 2'd1;
         OP_SWAP, [OP_ADD:OP_XOR], OP_SHL, OP_SHR,
         [OP_STORE8:OP_STORE64], [OP_JG:OP_JLE],
         OP_THREAD:                                    n = 2'd2;
         default:                                      n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] push_cnt(input logic [5:0] cmd);
      logic [1:0] n;
      case (cmd) inside
         [OP_PUSH8:OP_PUSH64], [OP_ADD:OP_SHR], [OP_LOAD8:OP_LOAD64],
         OP_CALL, OP_THREAD, OP_PUSHP:                 n = 2'd1;
         OP_DUP, OP_SWAP:                              n = 2'd2;
         default:                                      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/smeu_ifs.sv
// Handshake channel interfaces of the execute unit
interface smeu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  cmd;
   logic [63:0] imm;
   modport source (output valid, cmd, imm, input ready);
   modport sink   (input valid, cmd, imm, output ready);
endinterface

interface smeu_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [15:0] next_ip;
   logic [63:0] top_value;
   logic [8:0]  stack_depth;
   logic        running;
   logic        host_valid;
   logic        host_kind;
   logic [63:0] host_value;
   logic [63:0] return_value;
   modport source (output valid, status, next_ip, top_value, stack_depth, running,
                   host_valid, host_kind, host_value, return_value, input ready);
   modport sink   (input valid, status, next_ip, top_value, stack_depth, running,
                   host_valid, host_kind, host_value, return_value, output ready);
endinterface

interface smeu_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

// File: rtl/smeu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
module smeu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/smeu_muldiv.sv
// Iterative multiplier and unsigned divider, one bit per cycle
module smeu_muldiv import smeu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  md_ctl_type        ctl,
   input  logic [WORD_W-1:0] opa,
   input  logic [WORD_W-1:0] opb,
   output logic              done,
   output logic [WORD_W-1:0] result
);

   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              div_ff, div_in;
   logic              mod_ff, mod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] x_ff, x_in;   // multiplicand / quotient
   logic [WORD_W-1:0] y_ff, y_in;   // multiplier / divisor
   logic [WORD_W-1:0] z_ff, z_in;   // accumulator / remainder
   logic [WORD_W:0]   rem_t;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      rem_t   = {z_ff, x_ff[WORD_W-1]};
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.is_div;
         mod_in  = ctl.is_mod;
         cnt_in  = '0;
         x_in    = opa;
         y_in    = opb;
         z_in    = '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (rem_t >= {1'b0, y_ff}) begin
               z_in = WORD_W'(rem_t - {1'b0, y_ff});
               x_in = {x_ff[WORD_W-2:0], 1'b1};
            end else begin
               z_in = rem_t[WORD_W-1:0];
               x_in = {x_ff[WORD_W-2:0], 1'b0};
            end
         end else begin
            if (y_ff[0]) begin
               z_in = z_ff + x_ff;
            end
            x_in = {x_ff[WORD_W-2:0], 1'b0};
            y_in = {1'b0, y_ff[WORD_W-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      mod_ff <= mod_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done   = done_ff;
   assign result = (div_ff && !mod_ff) ? x_ff : z_ff;

endmodule

// File: rtl/stack_machine_execute_unit.sv
// Execute unit: each word passes through stack reads, exec, any writes and a top-of-stack reread;
// mul/divu/modu also wait on the bit-serial unit, and loads/stores go byte by byte
// through the single byte port of the heap RAM. One word in flight at a time.
// Synchronous reset; after reset a clearing pass zeroes the heap, one byte a
// cycle, during which no word is taken (config writes still are).
module stack_machine_execute_unit import smeu_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   smeu_req_if.sink   req_port,
   smeu_rsp_if.source rsp_port,
   smeu_csr_if.sink   csr_port
);

   seq_state_type state_ff, state_in;

   logic [5:0]        cmd_ff, cmd_in;
   logic [WORD_W-1:0] imm_ff, imm_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] r_ff, r_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic              run_ff, run_in;
   logic [WORD_W-1:0] ret_ff, ret_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [SIDX_W-1:0] wbase_ff, wbase_in;
   logic [1:0]        nwr_ff, nwr_in;
   logic [IP_W-1:0]   start_ff, start_in;
   logic [3:0]        status_ff, status_in;
   logic              hv_ff, hv_in;
   logic              hk_ff, hk_in;
   logic [WORD_W-1:0] hval_ff, hval_in;
   logic [HIDX_W-1:0] haddr_ff, haddr_in;
   logic [2:0]        hcnt_ff, hcnt_in;
   logic [HIDX_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        o_status_ff, o_status_in;
   logic [IP_W-1:0]   o_ip_ff, o_ip_in;
   logic [WORD_W-1:0] o_top_ff, o_top_in;
   logic [SP_W-1:0]   o_sp_ff, o_sp_in;
   logic              o_run_ff, o_run_in;
   logic              o_hv_ff, o_hv_in;
   logic              o_hk_ff, o_hk_in;
   logic [WORD_W-1:0] o_hval_ff, o_hval_in;
   logic [WORD_W-1:0] o_ret_ff, o_ret_in;

   // stack and heap RAM ports
   logic              s_we;
   logic [SIDX_W-1:0] s_waddr, s_raddr;
   logic [WORD_W-1:0] s_wdata, s_rdata;
   logic              h_we;
   logic [HIDX_W-1:0] h_waddr, h_raddr;
   logic [7:0]        h_wdata, h_rdata;

   md_ctl_type        md_ctl;
   logic              md_done;
   logic [WORD_W-1:0] md_res;

   // execute-stage decisions
   logic [3:0]        ex_status;
   logic              ex_run, ex_md, ex_heap, ex_load;
   logic [IP_W-1:0]   ex_ip;
   logic [SP_W-1:0]   ex_sp;
   logic [SIDX_W-1:0] ex_wbase;
   logic [1:0]        ex_nwr;
   logic [WORD_W-1:0] ex_r, ex_ret, ex_hval;
   logic              ex_hv, ex_hk;
   logic [2:0]        ex_hcnt;
   logic [HIDX_W-1:0] ex_haddr;

   logic [1:0]        need, push;
   logic [IP_W-1:0]   ipn, ip_off;
   logic [WORD_W-1:0] a_val, haddr_full;
   logic [1:0]        sz_idx;
   logic [3:0]        nbytes;
   logic              take, heap_bad, rsp_free;
   logic [SP_W:0]     sp_after;

   smeu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   smeu_ram #(.WIDTH(8), .DEPTH(HEAP_BYTES)) u_heap (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   smeu_muldiv u_muldiv (
      .clock(clock), .reset(reset), .ctl(md_ctl), .opa(a_val), .opb(b_ff),
      .done(md_done), .result(md_res)
   );

   assign req_port.ready = (state_ff == S_IDLE);
   assign csr_port.ready = 1'b1;
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;

   // decode and execute of the word held in cmd_ff / imm_ff; a arrives from RAM now
   always_comb begin
      a_val      = s_rdata;
      need       = need_cnt(cmd_ff);
      push       = push_cnt(cmd_ff);
      ipn        = ip_ff + IP_W'(1) + IP_W'(imm_len(cmd_ff));
      ip_off     = ipn + imm_ff[IP_W-1:0];
      sz_idx     = 2'(cmd_ff - OP_LOAD8);
      nbytes     = 4'd1 << sz_idx;
      ex_load    = (cmd_ff <= OP_LOAD64);
      haddr_full = ex_load ? b_ff : a_val;
      heap_bad   = (haddr_full >= WORD_W'(HEAP_BYTES)) ||
                   ({1'b0, haddr_full[HIDX_W-1:0]} + HCNT_W'(nbytes) > HCNT_W'(HEAP_BYTES));
      sp_after   = {1'b0, sp_ff} - (SP_W+1)'(need) + (SP_W+1)'(push);
      take       = 1'b0;
      ex_status  = ST_OK;
      ex_run     = run_ff;
      ex_md      = 1'b0;
      ex_heap    = 1'b0;
      ex_ip      = ip_ff;
      ex_sp      = sp_ff;
      ex_wbase   = SIDX_W'(sp_ff - SP_W'(need));
      ex_nwr     = 2'd0;
      ex_r       = '0;
      ex_ret     = ret_ff;
      ex_hv      = 1'b0;
      ex_hk      = 1'b0;
      ex_hval    = '0;
      ex_hcnt    = 3'(nbytes - 4'd1);
      ex_haddr   = haddr_full[HIDX_W-1:0];
      if (cmd_ff == OP_START) begin
         ex_ip  = start_ff;
         ex_run = 1'b1;
      end else if (cmd_ff == OP_PUSHP) begin
         if (sp_ff >= SP_W'(STACK_DEPTH)) begin
            ex_status = ST_OVER;
            ex_run    = 1'b0;
         end else begin
            ex_r     = imm_ff;
            ex_wbase = SIDX_W'(sp_ff);
            ex_nwr   = 2'd1;
            ex_sp    = sp_ff + 1'b1;
         end
      end else if (cmd_ff > OP_PUSHP) begin
         ex_status = ST_BADCMD;
         ex_run    = 1'b0;
      end else if (!run_ff) begin
         ex_status = ST_IDLE;
      end else if (cmd_ff == OP_HALT) begin
         if (sp_ff != '0) begin
            ex_ret = b_ff;
            ex_sp  = sp_ff - 1'b1;
         end
         ex_ip     = ipn;
         ex_run    = 1'b0;
         ex_status = ST_HALT;
      end else begin
         if (cmd_ff == OP_HOST && imm_ff[7:0] > 8'd1) begin
            ex_status = ST_HOST;
         end else if (sp_ff < SP_W'(need)) begin
            ex_status = ST_UNDER;
         end else if (sp_after > (SP_W+1)'(STACK_DEPTH)) begin
            ex_status = ST_OVER;
         end else if ((cmd_ff == OP_DIVU || cmd_ff == OP_MODU) && b_ff == '0) begin
            ex_status = ST_DIVZ;
         end else if (cmd_ff >= OP_LOAD8 && cmd_ff <= OP_STORE64 && heap_bad) begin
            ex_status = ST_HEAP;
         end
         if (ex_status != ST_OK) begin
            ex_run = 1'b0;
         end else begin
            case (cmd_ff)
               OP_PUSH8:  ex_r = {56'd0, imm_ff[7:0]};
               OP_PUSH16: ex_r = {48'd0, imm_ff[15:0]};
               OP_PUSH32: ex_r = {32'd0, imm_ff[31:0]};
               OP_PUSH64: ex_r = imm_ff;
               OP_DUP:    ex_r = b_ff;
               OP_ADD:    ex_r = a_val + b_ff;
               OP_SUB:    ex_r = a_val - b_ff;
               OP_AND:    ex_r = a_val & b_ff;
               OP_OR:     ex_r = a_val | b_ff;
               OP_XOR:    ex_r = a_val ^ b_ff;
               OP_NOT:    ex_r = ~b_ff;
               OP_SHL:    ex_r = (b_ff >= WORD_W'(WORD_W)) ? '0 : (a_val << b_ff[5:0]);
               OP_SHR:    ex_r = (b_ff >= WORD_W'(WORD_W)) ? '0 : (a_val >> b_ff[5:0]);
               OP_JMP:    take = 1'b1;
               OP_JZ:     take = (b_ff == '0);
               OP_JNZ:    take = (b_ff != '0);
               OP_JG:     take = (a_val > b_ff);
               OP_JL:     take = (a_val < b_ff);
               OP_JGE:    take = (a_val >= b_ff);
               OP_JLE:    take = (a_val <= b_ff);
               OP_CALL:   ex_r = WORD_W'(ipn);
               OP_HOST: begin
                  ex_hv   = 1'b1;
                  ex_hk   = imm_ff[0];
                  ex_hval = imm_ff[0] ? {56'd0, b_ff[7:0]} : b_ff;
               end
               default:   ex_r = '0;
            endcase
            if (cmd_ff == OP_CALL || cmd_ff == OP_RET) begin
               ex_ip = b_ff[IP_W-1:0];
            end else begin
               ex_ip = take ? ip_off : ipn;
            end
            ex_md   = (cmd_ff == OP_MUL || cmd_ff == OP_DIVU || cmd_ff == OP_MODU);
            ex_heap = (cmd_ff >= OP_LOAD8 && cmd_ff <= OP_STORE64);
            ex_sp   = sp_after[SP_W-1:0];
            ex_nwr  = (cmd_ff == OP_SWAP) ? 2'd2 : push;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE:   if (req_port.valid) state_in = S_RDB;
         S_RDB:    state_in = S_RDA;
         S_RDA:    state_in = S_EXEC;
         S_EXEC: begin
            if (ex_md) begin
               state_in = S_MULDIV;
            end else if (ex_heap) begin
               state_in = S_HRD;
            end else if (ex_nwr != 2'd0) begin
               state_in = S_WR0;
            end else begin
               state_in = S_TOP;
            end
         end
         S_MULDIV: if (md_done) state_in = S_WR0;
         S_HRD: begin
            if (ex_load) begin
               state_in = S_HDAT;
            end else if (hcnt_ff == '0) begin
               state_in = S_TOP;
            end
         end
         S_HDAT: state_in = (hcnt_ff == '0) ? S_WR0 : S_HRD;
         S_WR0:  state_in = (nwr_ff == 2'd2) ? S_WR1 : S_TOP;
         S_WR1:  state_in = S_TOP;
         S_TOP:  state_in = S_TOPC;
         S_TOPC: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in      = cmd_ff;
      imm_in      = imm_ff;
      b_in        = b_ff;
      a_in        = a_ff;
      r_in        = r_ff;
      ip_in       = ip_ff;
      run_in      = run_ff;
      ret_in      = ret_ff;
      sp_in       = sp_ff;
      wbase_in    = wbase_ff;
      nwr_in      = nwr_ff;
      status_in   = status_ff;
      hv_in       = hv_ff;
      hk_in       = hk_ff;
      hval_in     = hval_ff;
      haddr_in    = haddr_ff;
      hcnt_in     = hcnt_ff;
      clr_in      = clr_ff;
      start_in    = csr_port.valid ? csr_port.wdata : start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      o_status_in = o_status_ff;
      o_ip_in     = o_ip_ff;
      o_top_in    = o_top_ff;
      o_sp_in     = o_sp_ff;
      o_run_in    = o_run_ff;
      o_hv_in     = o_hv_ff;
      o_hk_in     = o_hk_ff;
      o_hval_in   = o_hval_ff;
      o_ret_in    = o_ret_ff;
      s_we        = 1'b0;
      s_waddr     = wbase_ff;
      s_wdata     = r_ff;
      s_raddr     = SIDX_W'(sp_ff - 1'b1);
      h_we        = 1'b0;
      h_waddr     = haddr_ff + HIDX_W'(hcnt_ff);
      h_wdata     = b_ff[{hcnt_ff, 3'b000} +: 8];
      h_raddr     = haddr_ff + HIDX_W'(hcnt_ff);
      md_ctl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            h_we    = 1'b1;
            h_waddr = clr_ff;
            h_wdata = '0;
            clr_in  = clr_ff + 1'b1;
         end
         S_IDLE: begin
            cmd_in = req_port.cmd;
            imm_in = req_port.imm;
         end
         S_RDB: begin
            s_raddr = SIDX_W'(sp_ff - 1'b1);
         end
         S_RDA: begin
            b_in    = s_rdata;
            s_raddr = SIDX_W'(sp_ff - SP_W'(2));
         end
         S_EXEC: begin
            a_in      = a_val;
            r_in      = ex_r;
            status_in = ex_status;
            run_in    = ex_run;
            ip_in     = ex_ip;
            sp_in     = ex_sp;
            ret_in    = ex_ret;
            wbase_in  = ex_wbase;
            nwr_in    = ex_nwr;
            hv_in     = ex_hv;
            hk_in     = ex_hk;
            hval_in   = ex_hval;
            haddr_in  = ex_haddr;
            hcnt_in   = ex_hcnt;
            md_ctl.start  = ex_md;
            md_ctl.is_div = (cmd_ff != OP_MUL);
            md_ctl.is_mod = (cmd_ff == OP_MODU);
         end
         S_MULDIV: begin
            if (md_done) r_in = md_res;
         end
         S_HRD: begin
            // stores write one byte per cycle, little-endian; loads go high byte first
            if (!ex_load) begin
               h_we = 1'b1;
               if (hcnt_ff != '0) hcnt_in = hcnt_ff - 1'b1;
            end
         end
         S_HDAT: begin
            r_in = {r_ff[WORD_W-9:0], h_rdata};
            if (hcnt_ff != '0) hcnt_in = hcnt_ff - 1'b1;
         end
         S_WR0: begin
            s_we    = 1'b1;
            s_waddr = wbase_ff;
            s_wdata = (cmd_ff == OP_SWAP) ? b_ff : r_ff;
         end
         S_WR1: begin
            s_we    = 1'b1;
            s_waddr = wbase_ff + 1'b1;
            s_wdata = (cmd_ff == OP_SWAP) ? a_ff : r_ff;
         end
         S_TOP: begin
            s_raddr = SIDX_W'(sp_ff - 1'b1);
         end
         S_TOPC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               o_status_in  = status_ff;
               o_ip_in      = ip_ff;
               o_top_in     = (sp_ff == '0) ? '0 : s_rdata;
               o_sp_in      = sp_ff;
               o_run_in     = run_ff;
               o_hv_in      = hv_ff;
               o_hk_in      = hk_ff;
               o_hval_in    = hval_ff;
               o_ret_in     = ret_ff;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ip_ff        <= '0;
         run_ff       <= 1'b0;
         ret_ff       <= '0;
         sp_ff        <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ip_ff        <= ip_in;
         run_ff       <= run_in;
         ret_ff       <= ret_in;
         sp_ff        <= sp_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      imm_ff      <= imm_in;
      b_ff        <= b_in;
      a_ff        <= a_in;
      r_ff        <= r_in;
      wbase_ff    <= wbase_in;
      nwr_ff      <= nwr_in;
      status_ff   <= status_in;
      hv_ff       <= hv_in;
      hk_ff       <= hk_in;
      hval_ff     <= hval_in;
      haddr_ff    <= haddr_in;
      hcnt_ff     <= hcnt_in;
      o_status_ff <= o_status_in;
      o_ip_ff     <= o_ip_in;
      o_top_ff    <= o_top_in;
      o_sp_ff     <= o_sp_in;
      o_run_ff    <= o_run_in;
      o_hv_ff     <= o_hv_in;
      o_hk_ff     <= o_hk_in;
      o_hval_ff   <= o_hval_in;
      o_ret_ff    <= o_ret_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = o_status_ff;
   assign rsp_port.next_ip      = o_ip_ff;
   assign rsp_port.top_value    = o_top_ff;
   assign rsp_port.stack_depth  = o_sp_ff;
   assign rsp_port.running      = o_run_ff;
   assign rsp_port.host_valid   = o_hv_ff;
   assign rsp_port.host_kind    = o_hk_ff;
   assign rsp_port.host_value   = o_hval_ff;
   assign rsp_port.return_value = o_ret_ff;

endmodule

// File: rtl/smeu_checker.sv
// Port-level checker for the execute unit and its bind
`include "stack_machine_execute_unit_macros.svh"

module smeu_checker import smeu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  status,
   input logic [63:0] top_value,
   input logic [8:0]  stack_depth,
   input logic        running,
   input logic        host_valid,
   input logic        host_kind,
   input logic [63:0] host_value
);

   `SMEU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
   `SMEU_ASSERT_NOW(a_halt_stops, clock, reset, rsp_valid && status == ST_HALT, !running)
   `SMEU_ASSERT_NOW(a_empty_top, clock, reset, rsp_valid && stack_depth == 9'd0, top_value == 64'd0)
   `SMEU_ASSERT_NOW(a_host_quiet, clock, reset, rsp_valid && !host_valid, !host_kind && host_value == 64'd0)

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_port.valid), .rsp_ready(rsp_port.ready),
   .status(rsp_port.status), .top_value(rsp_port.top_value),
   .stack_depth(rsp_port.stack_depth), .running(rsp_port.running),
   .host_valid(rsp_port.host_valid), .host_kind(rsp_port.host_kind),
   .host_value(rsp_port.host_value)
);

// File: tb/tb_stack_machine_execute_unit.sv
// Self-checking testbench of the stack machine execute unit
module tb_stack_machine_execute_unit;
   import smeu_pkg::*;

   localparam logic [5:0] OP_LOAD16  = OP_LOAD8 + 6'd1;
   localparam logic [5:0] OP_LOAD32  = OP_LOAD8 + 6'd2;
   localparam logic [5:0] OP_STORE16 = OP_STORE8 + 6'd1;
   localparam logic [5:0] OP_STORE32 = OP_STORE8 + 6'd2;
   localparam logic [5:0] OP_BAD_LO  = OP_PUSHP + 6'd1;
   localparam logic [5:0] OP_BAD_HI  = 6'h3f;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_WORDS = 930;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] next_ip;
      logic [63:0] top_value;
      logic [8:0]  stack_depth;
      logic        running;
      logic        host_valid;
      logic        host_kind;
      logic [63:0] host_value;
      logic [63:0] return_value;
   } vm_result_type;

   logic clock = 1'b0;
   logic reset;

   smeu_req_if req_bus();
   smeu_rsp_if rsp_bus();
   smeu_csr_if csr_bus();

   stack_machine_execute_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // machine state mirror
   logic [15:0] vm_start_addr;
   logic [15:0] vm_ip;
   logic        vm_running;
   logic [63:0] vm_ret_word;
   int          vm_sp;
   logic [63:0] vm_stack [STACK_DEPTH];
   logic [7:0]  vm_heap  [HEAP_BYTES];

   vm_result_type pending_results[$];
   int  fail_cnt = 0;
   int  cycle_cnt = 0;
   bit  quiet_mode = 1'b0;
   int  hold_req = 0;
   int  hold_seen = 0;
   int  stall_left = 0;

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(99);
      if (quiet_mode || roll < 70) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic int operand_count(logic [5:0] cmd);
      case (cmd)
         OP_POP, OP_DUP, OP_NOT, OP_LOAD8, OP_LOAD16, OP_LOAD32, OP_LOAD64,
         OP_JZ, OP_JNZ, OP_CALL, OP_RET, OP_HOST: return 1;
         OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIVU, OP_MODU, OP_AND, OP_OR,
         OP_XOR, OP_SHL, OP_SHR, OP_STORE8, OP_STORE16, OP_STORE32, OP_STORE64,
         OP_JG, OP_JL, OP_JGE, OP_JLE, OP_THREAD: return 2;
         default: return 0;
      endcase
   endfunction

   function automatic int result_count(logic [5:0] cmd);
      case (cmd)
         OP_DUP, OP_SWAP: return 2;
         OP_POP, OP_STORE8, OP_STORE16, OP_STORE32, OP_STORE64, OP_JMP, OP_JZ,
         OP_JNZ, OP_JG, OP_JL, OP_JGE, OP_JLE, OP_RET, OP_HOST, OP_HALT: return 0;
         default: return 1;
      endcase
   endfunction

   function automatic logic [15:0] word_length(logic [5:0] cmd);
      case (cmd)
         OP_PUSH8, OP_HOST: return 16'd2;
         OP_PUSH16, OP_JMP, OP_JZ, OP_JNZ, OP_JG, OP_JL, OP_JGE, OP_JLE: return 16'd3;
         OP_PUSH32: return 16'd5;
         OP_PUSH64: return 16'd9;
         default: return 16'd1;
      endcase
   endfunction

   // one instruction on a running machine; returns its status
   function automatic logic [3:0] run_instruction(input logic [5:0] cmd,
         input logic [63:0] imm, output logic hv, output logic hk,
         output logic [63:0] hval);
      logic [15:0] ipn;
      logic [63:0] a, b, r, addr;
      int need, push, nbytes;
      bit taken;
      a = '0; b = '0; r = '0; taken = 1'b0;
      hv = 1'b0; hk = 1'b0; hval = '0;
      ipn = vm_ip + word_length(cmd);
      if (cmd == OP_HALT) begin
         if (vm_sp > 0) begin
            vm_ret_word = vm_stack[vm_sp-1];
            vm_sp--;
         end
         vm_ip = ipn;
         return ST_HALT;
      end
      need = operand_count(cmd);
      push = result_count(cmd);
      if (cmd == OP_HOST && imm[7:0] > 8'd1) return ST_HOST;
      if (vm_sp < need) return ST_UNDER;
      if (vm_sp - need + push > STACK_DEPTH) return ST_OVER;
      if (need >= 1) b = vm_stack[vm_sp-1];
      if (need >= 2) a = vm_stack[vm_sp-2];
      if ((cmd == OP_DIVU || cmd == OP_MODU) && b == 0) return ST_DIVZ;
      if (cmd >= OP_LOAD8 && cmd <= OP_STORE64) begin
         addr = (cmd <= OP_LOAD64) ? b : a;
         nbytes = 1 << ((cmd - OP_LOAD8) & 3);
         if (addr >= HEAP_BYTES || nbytes > HEAP_BYTES - addr) return ST_HEAP;
         for (int i = 0; i < nbytes; i++)
            if (cmd <= OP_LOAD64) r[8*i +: 8] = vm_heap[addr + i];
            else vm_heap[addr + i] = b[8*i +: 8];
      end
      case (cmd)
         OP_PUSH8:  r = {56'd0, imm[7:0]};
         OP_PUSH16: r = {48'd0, imm[15:0]};
         OP_PUSH32: r = {32'd0, imm[31:0]};
         OP_PUSH64: r = imm;
         OP_DUP:    r = b;
         OP_ADD:    r = a + b;
         OP_SUB:    r = a - b;
         OP_MUL:    r = a * b;
         OP_DIVU:   r = a / b;
         OP_MODU:   r = a % b;
         OP_AND:    r = a & b;
         OP_OR:     r = a | b;
         OP_XOR:    r = a ^ b;
         OP_NOT:    r = ~b;
         OP_SHL:    r = (b >= 64) ? '0 : a << b[5:0];
         OP_SHR:    r = (b >= 64) ? '0 : a >> b[5:0];
         OP_JMP:    taken = 1'b1;
         OP_JZ:     taken = (b == 0);
         OP_JNZ:    taken = (b != 0);
         OP_JG:     taken = (a > b);
         OP_JL:     taken = (a < b);
         OP_JGE:    taken = (a >= b);
         OP_JLE:    taken = (a <= b);
         OP_CALL: begin
            r = {48'd0, ipn};
            ipn = b[15:0];
         end
         OP_RET:    ipn = b[15:0];
         OP_HOST: begin
            hv = 1'b1;
            hk = imm[0];
            hval = hk ? {56'd0, b[7:0]} : b;
         end
         default: ;
      endcase
      if (taken) ipn = ipn + imm[15:0];  // 16-bit wrap gives the signed offset
      vm_sp -= need;
      if (cmd == OP_SWAP) begin
         vm_stack[vm_sp] = b;
         vm_stack[vm_sp+1] = a;
      end else if (push == 2) begin
         vm_stack[vm_sp] = r;
         vm_stack[vm_sp+1] = r;
      end else if (push == 1) begin
         vm_stack[vm_sp] = r;
      end
      vm_sp += push;
      vm_ip = ipn;
      return ST_OK;
   endfunction

   function automatic vm_result_type predict_word(logic [5:0] cmd, logic [63:0] imm);
      vm_result_type res;
      logic hv, hk;
      logic [63:0] hval;
      hv = 1'b0; hk = 1'b0; hval = '0;
      res.status = ST_OK;
      if (cmd == OP_START) begin
         vm_ip = vm_start_addr;
         vm_running = 1'b1;
      end else if (cmd == OP_PUSHP) begin
         if (vm_sp >= STACK_DEPTH) begin
            res.status = ST_OVER;
            vm_running = 1'b0;
         end else begin
            vm_stack[vm_sp] = imm;
            vm_sp++;
         end
      end else if (cmd > OP_PUSHP) begin
         res.status = ST_BADCMD;
         vm_running = 1'b0;
      end else if (!vm_running) begin
         res.status = ST_IDLE;
      end else begin
         res.status = run_instruction(cmd, imm, hv, hk, hval);
         if (res.status != ST_OK) vm_running = 1'b0;
      end
      res.next_ip = vm_ip;
      res.top_value = (vm_sp > 0) ? vm_stack[vm_sp-1] : '0;
      res.stack_depth = vm_sp[8:0];
      res.running = vm_running;
      res.host_valid = hv;
      res.host_kind = hk;
      res.host_value = hval;
      res.return_value = vm_ret_word;
      return res;
   endfunction

   // offer one word; returns once it is taken, valid left high
   task automatic send_word(input logic [5:0] cmd, input logic [63:0] imm);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.imm <= imm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(predict_word(cmd, imm));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_start_addr(input logic [15:0] addr);
      csr_bus.valid <= 1'b1;
      csr_bus.wdata <= addr;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      vm_start_addr = addr;
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [63:0] pick_operand();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3, 4: return $urandom_range(HEAP_BYTES + 4);
         5: return $urandom_range(70);
         6: return HEAP_BYTES - $urandom_range(8, 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_directed();
      write_start_addr(16'hfffe);
      send_word(OP_ADD, 64'd0);                 // not running
      send_word(OP_START, '0);
      send_word(OP_PUSH8, '1);
      send_word(OP_PUSH16, '1);
      send_word(OP_PUSH32, '1);
      send_word(OP_PUSH64, '1);
      send_word(OP_POP, '0);
      send_word(OP_DUP, '0);
      send_word(OP_SWAP, '0);
      send_word(OP_ADD, '0);
      send_word(OP_SUB, '0);
      send_word(OP_PUSHP, 64'd3);
      send_word(OP_MUL, '0);
      send_word(OP_PUSHP, 64'd0);
      send_word(OP_MODU, '0);                   // divide by zero
      send_word(OP_START, '0);
      send_word(OP_PUSHP, 64'd64);
      send_word(OP_SHL, '0);                    // shift of 64 gives 0
      send_word(OP_NOT, '0);
      send_word(OP_PUSHP, 64'd4095);
      send_word(OP_LOAD8, '0);
      send_word(OP_JMP, 64'h8000);
      send_word(OP_HOST, 64'd2);                // bad host id
      send_word(OP_BAD_HI, '0);
      drain();
   endtask

   task automatic test_stack_limits();
      send_word(OP_START, '0);
      send_word(OP_POP, '0);
      while (vm_sp < STACK_DEPTH) send_word(OP_PUSHP, {$urandom, $urandom});
      send_word(OP_PUSHP, '1);                  // overflow
      send_word(OP_START, '0);
      send_word(OP_DUP, '0);
      send_word(OP_START, '0);
      while (vm_sp > 0) send_word(OP_POP, '0);
      send_word(OP_HALT, '0);                   // halt on empty stack
      drain();
   endtask

   task automatic random_word();
      logic [5:0] cmd;
      logic [63:0] imm;
      int roll;
      roll = $urandom_range(99);
      imm = {$urandom, $urandom};
      if (roll < 3) cmd = $urandom_range(OP_BAD_HI, OP_BAD_LO);
      else if (!vm_running && roll < 80) cmd = OP_START;
      else if (vm_sp < 3 || roll < 30) begin
         cmd = OP_PUSHP;
         imm = pick_operand();
      end else if (roll < 33) cmd = OP_HALT;
      else begin
         cmd = $urandom_range(OP_THREAD, OP_PUSH8);
         if (cmd == OP_HOST && $urandom_range(9) != 0) imm[7:1] = '0;
      end
      send_word(cmd, imm);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) quiet_mode = ($urandom_range(4) == 0);
         random_word();
      end
      quiet_mode = 1'b0;
      drain();
   endtask

   task automatic test_backpressure();
      hold_req++;
      send_word(OP_START, '0);
      for (int i = 0; i < 30; i++) random_word();
      drain();
   endtask

   // result side stall control
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         stall_left <= 400;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_left <= gap_len();
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vm_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expectation");
            fail_cnt++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_bus.status !== exp_res.status) begin
               $error("status exp %0d got %0d", exp_res.status, rsp_bus.status);
               fail_cnt++;
            end
            if (rsp_bus.next_ip !== exp_res.next_ip) begin
               $error("next_ip exp %h got %h", exp_res.next_ip, rsp_bus.next_ip);
               fail_cnt++;
            end
            if (rsp_bus.top_value !== exp_res.top_value) begin
               $error("top_value exp %h got %h", exp_res.top_value, rsp_bus.top_value);
               fail_cnt++;
            end
            if (rsp_bus.stack_depth !== exp_res.stack_depth) begin
               $error("stack_depth exp %0d got %0d", exp_res.stack_depth,
                      rsp_bus.stack_depth);
               fail_cnt++;
            end
            if (rsp_bus.running !== exp_res.running) begin
               $error("running exp %b got %b", exp_res.running, rsp_bus.running);
               fail_cnt++;
            end
            if (rsp_bus.host_valid !== exp_res.host_valid) begin
               $error("host_valid exp %b got %b", exp_res.host_valid, rsp_bus.host_valid);
               fail_cnt++;
            end
            if (rsp_bus.host_kind !== exp_res.host_kind) begin
               $error("host_kind exp %b got %b", exp_res.host_kind, rsp_bus.host_kind);
               fail_cnt++;
            end
            if (rsp_bus.host_value !== exp_res.host_value) begin
               $error("host_value exp %h got %h", exp_res.host_value, rsp_bus.host_value);
               fail_cnt++;
            end
            if (rsp_bus.return_value !== exp_res.return_value) begin
               $error("return_value exp %h got %h", exp_res.return_value,
                      rsp_bus.return_value);
               fail_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= '0;
      req_bus.imm <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.wdata <= '0;
      vm_start_addr = '0;
      vm_ip = '0;
      vm_running = 1'b0;
      vm_ret_word = '0;
      vm_sp = 0;
      foreach (vm_stack[i]) vm_stack[i] = '0;
      foreach (vm_heap[i]) vm_heap[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_stack_limits();
      write_start_addr(16'h0000);
      test_random(RANDOM_WORDS / 3);
      write_start_addr(16'hffff);
      test_backpressure();
      write_start_addr($urandom_range(16'hffff));
      test_random(RANDOM_WORDS / 3);
      write_start_addr(16'h8000);
      test_random(RANDOM_WORDS / 3);

      if (fail_cnt == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
